[sv/bce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types, constants and the byte-wide CRC-32 update for the block
// checksum engine.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;
    localparam logic [8:0]  FLETCHER_MOD = 9'd255;

    // Checksum mode register codes
    localparam logic MODE_FLETCHER = 1'b0;
    localparam logic MODE_CRC      = 1'b1;

    // Per-byte step control from the input stage to the checksum units
    typedef struct packed {
        logic en;    // a byte is folded in this cycle
        logic last;  // that byte closes the block
    } t_step;

    // Reflected CRC-32 over one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[sv/bce_fletcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_fletcher
// Fletcher-16 sum pair, both modulo 255, cleared after the closing byte.
// ----------------------------------------------------------------------------
module bce_fletcher (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bce_pkg::t_step i_step,
    input  logic [7:0]     i_data_byte,
    output logic [7:0]     o_low_next,
    output logic [7:0]     o_high_next,
    output logic [7:0]     o_low,
    output logic [7:0]     o_high
);
    import bce_pkg::*;

    logic [7:0] r_low;
    logic [7:0] r_high;
    logic [7:0] n_low;
    logic [7:0] n_high;
    logic [8:0] low_sum;
    logic [8:0] high_sum;

    // Both sums stay below 255, so one compare and subtract folds each add
    always_comb begin
        low_sum = {1'b0, r_low} + {1'b0, i_data_byte};
        if (low_sum >= FLETCHER_MOD) begin
            low_sum = low_sum - FLETCHER_MOD;
        end
        n_low = low_sum[7:0];

        high_sum = {1'b0, r_high} + {1'b0, n_low};
        if (high_sum >= FLETCHER_MOD) begin
            high_sum = high_sum - FLETCHER_MOD;
        end
        n_high = high_sum[7:0];
    end

    // Sum registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= 8'd0;
            r_high <= 8'd0;
        end else if (i_step.en) begin
            if (i_step.last) begin
                r_low  <= 8'd0;
                r_high <= 8'd0;
            end else begin
                r_low  <= n_low;
                r_high <= n_high;
            end
        end
    end

    assign o_low_next  = n_low;
    assign o_high_next = n_high;
    assign o_low       = r_low;
    assign o_high      = r_high;

endmodule

[sv/bce_crc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_crc
// Reflected CRC-32 register, preset to all ones, reloaded after the closing
// byte.
// ----------------------------------------------------------------------------
module bce_crc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bce_pkg::t_step i_step,
    input  logic [7:0]     i_data_byte,
    output logic [31:0]    o_crc_next,
    output logic [31:0]    o_crc
);
    import bce_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] n_crc;

    // Eight shift-xor steps for one byte
    always_comb begin
        n_crc = crc_byte(r_crc, i_data_byte);
    end

    // CRC register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_PRESET;
        end else if (i_step.en) begin
            if (i_step.last) begin
                r_crc <= CRC_PRESET;
            end else begin
                r_crc <= n_crc;
            end
        end
    end

    assign o_crc_next = n_crc;
    assign o_crc      = r_crc;

endmodule

[sv/block_checksum_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_checksum_engine
// Fletcher-16 or CRC-32 checksum over a flagged byte stream, one block at a
// time; the mode register picks which value is reported on the last byte.
// ----------------------------------------------------------------------------
// Result path: the closing byte passes the input register, then the result
//   register, which raises o_valid and holds the checksum until it is taken.
// Throughput: one byte per cycle; only a closing byte stalls, and only while
//   an unaccepted checksum sits in the result register with i_ready low.
// Reset: synchronous, active low; mode is Fletcher-16, sums are zero, the
//   CRC is all ones and no transaction is pending.
module block_checksum_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    // byte input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // checksum output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_checksum
);
    import bce_pkg::*;

    logic        r_mode;
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        r_out_valid;
    logic [31:0] r_checksum;

    logic        advance;
    t_step       step;
    logic [7:0]  low_next;
    logic [7:0]  high_next;
    logic [7:0]  low_cur;
    logic [7:0]  high_cur;
    logic [31:0] crc_next;
    logic [31:0] crc_cur;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FLETCHER;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // A plain byte always moves on; a closing byte needs room in the result register
    assign advance  = r_in_valid && (!r_last || !r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || advance;
    assign step.en   = advance;
    assign step.last = r_last;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    bce_fletcher u_fletcher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_byte),
        .o_low_next  (low_next),
        .o_high_next (high_next),
        .o_low       (low_cur),
        .o_high      (high_cur)
    );

    bce_crc u_crc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_byte),
        .o_crc_next  (crc_next),
        .o_crc       (crc_cur)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            if (r_mode == MODE_CRC) begin
                r_checksum <= crc_next;
            end else begin
                r_checksum <= {16'd0, high_next, low_next};
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_checksum = r_checksum;

    // Sums never reach the modulus
    a_sums_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (low_cur != 8'hFF) && (high_cur != 8'hFF))
        else $error("fletcher sum reached 255");

    // Closing byte returns both checksums to their initial values
    a_block_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_last) |=> (crc_cur == CRC_PRESET) && (low_cur == 8'd0)
                                && (high_cur == 8'd0))
        else $error("checksum state not reinitialized after closing byte");

    // Input stage only stalls while holding a closing byte behind a full output
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_last && r_out_valid && !i_ready))
        else $error("input stalled without a blocked closing byte");

    // Fletcher results carry nothing in the upper half
    a_fletcher_upper : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_mode == MODE_FLETCHER)) |-> (o_checksum[31:16] == 16'd0))
        else $error("fletcher checksum has upper bits set");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for block_checksum_engine. A directed table covers the
// reset mode, the byte extremes, modulo wrap, single-byte blocks and mode
// changes in the middle of a block. It is followed by phases of random
// blocks, including a full-size map block. A local Fletcher-16 / CRC-32
// predictor forms the expected checksum of every flagged byte. Results are
// compared in order as they leave the block.
// ----------------------------------------------------------------------------
module testbench;

    import bce_pkg::*;

    localparam int DRAIN_CYCLES = 4;    // input and result registers, plus margin
    localparam int HOLD_AT      = 130;  // byte count that starts the long output stall
    localparam int HOLD_CYCLES  = 120;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_BYTES  = 30;
    localparam int NUM_DIR      = 19;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_checksum;

    // predictor state
    logic [7:0]  sum_lo;
    logic [7:0]  sum_hi;
    logic [31:0] crc_acc;
    logic        mode_now;

    logic [31:0] checksum_due[$];
    int          mismatches;
    int          bytes_accepted;
    bit          no_gaps;

    // one row of the directed table; fixed_chk is used only where has_fixed is set
    typedef struct packed {
        logic        wr_mode;
        logic        mode;
        logic [7:0]  data;
        logic        last;
        logic        has_fixed;
        logic [31:0] fixed_chk;
    } t_dir_row;

    t_dir_row dir_rows [NUM_DIR] = '{
        // Fletcher-16 straight out of reset
        '{1'b0, MODE_FLETCHER, 8'h00, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b0, MODE_FLETCHER, 8'hFF, 1'b1, 1'b1, 32'h0000_0000},  // 255 wraps to 0
        '{1'b0, MODE_FLETCHER, 8'h01, 1'b1, 1'b1, 32'h0000_0101},
        '{1'b0, MODE_FLETCHER, 8'hFE, 1'b1, 1'b1, 32'h0000_FEFE},
        '{1'b0, MODE_FLETCHER, 8'h80, 1'b0, 1'b0, 32'h0},
        '{1'b0, MODE_FLETCHER, 8'h7F, 1'b0, 1'b0, 32'h0},
        '{1'b0, MODE_FLETCHER, 8'hFF, 1'b0, 1'b0, 32'h0},
        '{1'b0, MODE_FLETCHER, 8'hAA, 1'b1, 1'b0, 32'h0},
        // CRC-32, no final inversion
        '{1'b1, MODE_CRC,      8'h00, 1'b1, 1'b1, 32'h2DFD_1072},
        '{1'b0, MODE_CRC,      8'hFF, 1'b1, 1'b1, 32'h00FF_FFFF},
        '{1'b0, MODE_CRC,      8'h55, 1'b0, 1'b0, 32'h0},
        '{1'b0, MODE_CRC,      8'hAA, 1'b1, 1'b0, 32'h0},
        // mode switched in the middle of a block
        '{1'b0, MODE_CRC,      8'h12, 1'b0, 1'b0, 32'h0},
        '{1'b1, MODE_FLETCHER, 8'h34, 1'b1, 1'b0, 32'h0},
        '{1'b0, MODE_FLETCHER, 8'h5A, 1'b0, 1'b0, 32'h0},
        '{1'b1, MODE_CRC,      8'hC3, 1'b1, 1'b0, 32'h0},
        '{1'b0, MODE_CRC,      8'h01, 1'b0, 1'b0, 32'h0},
        '{1'b0, MODE_CRC,      8'h02, 1'b0, 1'b0, 32'h0},
        '{1'b0, MODE_CRC,      8'h80, 1'b1, 1'b0, 32'h0}
    };

    block_checksum_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_checksum  (o_checksum)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Fold one byte into both running checksums; on a flagged byte report the
    // selected checksum and restart the sums.
    task automatic fold_byte(input logic [7:0] b, input logic l,
                             output logic [31:0] chk);
        logic [8:0] acc9;
        logic       fb;
        acc9 = {1'b0, sum_lo} + {1'b0, b};
        if (acc9 >= FLETCHER_MOD) begin
            acc9 = acc9 - FLETCHER_MOD;
        end
        sum_lo = acc9[7:0];
        acc9 = {1'b0, sum_hi} + {1'b0, sum_lo};
        if (acc9 >= FLETCHER_MOD) begin
            acc9 = acc9 - FLETCHER_MOD;
        end
        sum_hi = acc9[7:0];
        // bit-serial reflected CRC, LSB first
        for (int i = 0; i < 8; i++) begin
            fb = crc_acc[0] ^ b[i];
            crc_acc = crc_acc >> 1;
            if (fb) begin
                crc_acc = crc_acc ^ CRC_POLY;
            end
        end
        chk = (mode_now == MODE_CRC) ? crc_acc : {16'h0000, sum_hi, sum_lo};
        if (l) begin
            sum_lo  = 8'h00;
            sum_hi  = 8'h00;
            crc_acc = CRC_PRESET;
        end
    endtask

    // Offer one byte, with random gaps ahead of it, and wait for the transaction
    task automatic put_byte(input logic [7:0] b, input logic l,
                            input logic has_fixed, input logic [31:0] fixed_chk);
        logic [31:0] chk;
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        do @(posedge i_clk); while (!o_ready);
        bytes_accepted++;
        fold_byte(b, l, chk);
        if (l) begin
            checksum_due.push_back(has_fixed ? fixed_chk : chk);
        end
    endtask

    // Write the mode register once the block has gone idle
    task automatic set_mode(input logic m);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (checksum_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        mode_now = m;
    endtask

    // One block of random bytes, the last one flagged
    task automatic send_block(input int len);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(255));
            endcase
            put_byte(b, k == len - 1, 1'b0, 32'h0);
        end
    endtask

    // Output side: random back-pressure, one long stall
    initial begin
        bit held;
        held    = 1'b0;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && bytes_accepted >= HOLD_AT) begin
                held = 1'b1;
                i_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    @(negedge i_clk);
                end
            end else begin
                i_ready <= no_gaps || ($urandom_range(99) >= 18);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (checksum_due.size() == 0) begin
                $display("%0t: unexpected checksum %08h", $time, o_checksum);
                mismatches++;
            end else begin
                want = checksum_due.pop_front();
                if (o_checksum !== want) begin
                    $display("%0t: checksum mismatch, expected %08h, actual %08h",
                             $time, want, o_checksum);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int phase_start;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = MODE_FLETCHER;
        i_valid        = 1'b0;
        i_data_byte    = 8'h00;
        i_last_byte    = 1'b0;
        mismatches     = 0;
        bytes_accepted = 0;
        no_gaps        = 1'b0;
        sum_lo         = 8'h00;
        sum_hi         = 8'h00;
        crc_acc        = CRC_PRESET;
        mode_now       = MODE_FLETCHER;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < NUM_DIR; r++) begin
            if (dir_rows[r].wr_mode) begin
                set_mode(dir_rows[r].mode);
            end
            put_byte(dir_rows[r].data, dir_rows[r].last,
                     dir_rows[r].has_fixed, dir_rows[r].fixed_chk);
        end

        // random phases, the mode alternating between them
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_mode((ph % 2 == 0) ? MODE_FLETCHER : MODE_CRC);
            no_gaps = (ph == 1);
            if (ph == 4) begin
                // full map block: 192 land bytes plus statics
                send_block(192 + $urandom_range(24));
            end
            phase_start = bytes_accepted;
            while (bytes_accepted - phase_start < PHASE_BYTES) begin
                case ($urandom_range(19))
                    0, 1, 2:   send_block(1);
                    3, 4, 5:   send_block($urandom_range(30, 9));
                    default:   send_block($urandom_range(8, 2));
                endcase
            end
            // sometimes leave a block open across the mode change
            if ($urandom_range(9) < 4) begin
                for (int k = $urandom_range(3, 1); k > 0; k--) begin
                    put_byte(8'($urandom_range(255)), 1'b0, 1'b0, 32'h0);
                end
            end
        end
        send_block($urandom_range(6, 1));
        no_gaps = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (checksum_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4 * DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
